// ===== rtl/rat_pkg.sv =====
// ----------------------------------------------------------------------------
// rat_pkg
// shared constants, types and helper functions of the rssi tracking step
// ----------------------------------------------------------------------------
package rat_pkg;

    localparam int WINDOW    = 10;
    localparam int SLOPE_Q8  = 128;
    localparam int OFFSET_Q8 = 512;

    localparam int RSSI_W  = 10;
    localparam int ANGLE_W = 8;
    localparam int PCT_W   = 18;
    localparam int SUM_W   = $clog2(WINDOW * 1023 + 1);
    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // reciprocal of the window for an exact floor of sum / WINDOW
    localparam int RECIP_K = SUM_W + $clog2(WINDOW) + 1;
    localparam int RECIP_W = RECIP_K + 1;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam int STEP_DEPTH = 1 << RSSI_W;

    localparam logic [ANGLE_W-1:0] CAL_SPEED = 8'd40;
    localparam logic [ANGLE_W-1:0] STEP_CAP  = 8'd180;

    // register map
    localparam logic [2:0] REG_DEADBAND  = 3'd0;
    localparam logic [2:0] REG_ANGLE_MIN = 3'd1;
    localparam logic [2:0] REG_ANGLE_MAX = 3'd2;
    localparam logic [2:0] REG_DIR_NEG   = 3'd3;
    localparam logic [2:0] REG_DEF_SPEED = 3'd4;

    typedef logic [ANGLE_W-1:0] t_step_rom [0:STEP_DEPTH-1];

    // restoring long division, used only while the step table is built
    function automatic longint unsigned udiv64(
        input longint unsigned a,
        input longint unsigned b
    );
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], a[i]};
            if (rem >= b) begin
                rem  = rem - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid step, taylor series of e^z in 40-bit fraction fixed point
    function automatic logic [ANGLE_W-1:0] step_size(input int d);
        longint          n;
        longint unsigned un;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        int              j;
        n = 10 * longint'(OFFSET_Q8) - longint'(SLOPE_Q8) * longint'(d);
        if (n < 0) begin
            return 8'd1;
        end
        if (n > 16000) begin
            return STEP_CAP;
        end
        un   = longint'(unsigned'(n));
        term = 64'd1 << 40;
        sum  = term;
        j    = 1;
        while (j < 100 && term != 0) begin
            term = udiv64(term * un, 64'd2560 * longint'(unsigned'(j)));
            sum  = sum + term;
            j    = j + 1;
        end
        v = (sum >> 40) + 64'd1;
        return (v > 64'd180) ? STEP_CAP : ANGLE_W'(v);
    endfunction

    function automatic t_step_rom build_step_rom();
        t_step_rom rom;
        for (int i = 0; i < STEP_DEPTH; i++) begin
            rom[i] = step_size(i);
        end
        return rom;
    endfunction

    function automatic logic [ANGLE_W-1:0] clamp_angle(
        input logic signed [ANGLE_W+1:0] a,
        input logic [ANGLE_W-1:0]        amin,
        input logic [ANGLE_W-1:0]        amax
    );
        if (a < $signed({2'b00, amin})) begin
            return amin;
        end else if (a > $signed({2'b00, amax})) begin
            return amax;
        end
        return a[ANGLE_W-1:0];
    endfunction

endpackage

// ===== rtl/rat_div.sv =====
// ----------------------------------------------------------------------------
// rat_div
// serial signed divider for the percent mapping, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rat_div
    import rat_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [PCT_W-1:0] i_num,
    input  logic signed [RSSI_W:0]  i_den,
    output logic                    o_busy,
    output logic signed [PCT_W-1:0] o_quot
);

    localparam int MAG_W = PCT_W - 1;
    localparam int CNT_W = $clog2(MAG_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [MAG_W-1:0]    r_num;
    logic [MAG_W-1:0]    r_q;
    logic [RSSI_W-1:0]   r_rem;
    logic [RSSI_W:0]     r_den;
    logic                r_neg;
    logic                r_zero;

    logic [PCT_W-1:0]    num_abs;
    logic [RSSI_W:0]     den_abs;
    logic [RSSI_W:0]     trial;
    logic                fits;

    assign num_abs = i_num[PCT_W-1] ? PCT_W'(-i_num) : PCT_W'(i_num);
    assign den_abs = i_den[RSSI_W] ? (RSSI_W+1)'(-i_den) : (RSSI_W+1)'(i_den);
    assign trial   = {r_rem, r_num[MAG_W-1]};
    assign fits    = (trial >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(MAG_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= num_abs[MAG_W-1:0];
            r_den  <= den_abs;
            r_rem  <= '0;
            r_q    <= '0;
            r_neg  <= i_num[PCT_W-1] ^ i_den[RSSI_W];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_num <= {r_num[MAG_W-2:0], 1'b0};
            r_q   <= {r_q[MAG_W-2:0], fits};
            r_rem <= fits ? RSSI_W'(trial - r_den) : trial[RSSI_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_zero ? '0 : (r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q}));

endmodule

// ===== rtl/rat_step_rom.sv =====
// ----------------------------------------------------------------------------
// rat_step_rom
// step size table indexed by the averaged difference, registered read
// ----------------------------------------------------------------------------
module rat_step_rom
    import rat_pkg::*;
(
    input  logic               i_clk,
    input  logic [RSSI_W-1:0]  i_addr,
    output logic [ANGLE_W-1:0] o_data
);

    localparam t_step_rom STEP_ROM = build_step_rom();

    logic [ANGLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= STEP_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== rtl/rssi_antenna_tracking_step.sv =====
// ----------------------------------------------------------------------------
// rssi_antenna_tracking_step
// pan tracker step: percent mapping, window averages and sigmoid servo step
// ----------------------------------------------------------------------------
// result valid once both serial 17-bit percent dividers and the fsm are done;
// a new item is taken only in idle, after the last result is registered.
// history lives in a one-port memory with registered read, read then written
// back per item. reset (synchronous) restores register defaults, clears the
// sums, min/max, pointer, angle and the history valid bits at once.
module rssi_antenna_tracking_step
    import rat_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_command,
    input  logic [RSSI_W-1:0]       i_left_rssi,
    input  logic [RSSI_W-1:0]       i_right_rssi,
    input  logic [ANGLE_W-1:0]      i_target_angle,
    // output channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ANGLE_W-1:0]      o_servo_angle,
    output logic [ANGLE_W-1:0]      o_pan_speed,
    output logic signed [PCT_W-1:0] o_left_percent,
    output logic signed [PCT_W-1:0] o_right_percent
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_AVG  = 3'd3;
    localparam logic [2:0] S_ROM  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // configuration registers
    logic [RSSI_W-1:0]  r_deadband;
    logic [ANGLE_W-1:0] r_angle_min;
    logic [ANGLE_W-1:0] r_angle_max;
    logic               r_dir_neg;
    logic [ANGLE_W-1:0] r_def_speed;

    logic [2:0]         r_state;
    logic               r_cmd;
    logic [RSSI_W-1:0]  r_l;
    logic [RSSI_W-1:0]  r_r;
    logic [ANGLE_W-1:0] r_tgt;
    logic [PTR_W-1:0]   r_ptr;
    logic [SUM_W-1:0]   r_lsum;
    logic [SUM_W-1:0]   r_rsum;
    logic [RSSI_W-1:0]  r_llow;
    logic [RSSI_W-1:0]  r_lhigh;
    logic [RSSI_W-1:0]  r_rlow;
    logic [RSSI_W-1:0]  r_rhigh;
    logic [ANGLE_W-1:0] r_pan;
    logic [ANGLE_W-1:0] r_speed;
    logic [PROD_W-1:0]  r_lprod;
    logic [PROD_W-1:0]  r_rprod;
    logic               r_move;
    logic               r_neg;

    logic               r_out_vld;
    logic [ANGLE_W-1:0] r_out_angle;
    logic [ANGLE_W-1:0] r_out_speed;
    logic signed [PCT_W-1:0] r_out_lp;
    logic signed [PCT_W-1:0] r_out_rp;

    // history memory, {left, right} per entry
    logic [2*RSSI_W-1:0] r_hist [0:WINDOW-1];
    logic [WINDOW-1:0]   r_hist_vld;
    logic [2*RSSI_W-1:0] r_rd_data;
    logic                r_rd_vld;

    logic               accept;
    logic               cfg_wr;
    logic               done_go;
    logic [RSSI_W-1:0]  old_l;
    logic [RSSI_W-1:0]  old_r;
    logic [RSSI_W-1:0]  avg_l;
    logic [RSSI_W-1:0]  avg_r;
    logic [RSSI_W-1:0]  diff;
    logic [ANGLE_W-1:0] step_q;
    logic [RSSI_W-1:0]  step_rd;
    logic signed [ANGLE_W+1:0] new_angle;
    logic signed [PCT_W-1:0]   l_num;
    logic signed [PCT_W-1:0]   r_num_w;
    logic signed [RSSI_W:0]    l_den;
    logic signed [RSSI_W:0]    r_den_w;
    logic               ldiv_busy;
    logic               rdiv_busy;
    logic signed [PCT_W-1:0] l_quot;
    logic signed [PCT_W-1:0] r_quot;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign done_go = (r_state == S_DONE) && !ldiv_busy && !rdiv_busy
                     && (!r_out_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= 10'd10;
            r_angle_min <= 8'd0;
            r_angle_max <= 8'd180;
            r_dir_neg   <= 1'b0;
            r_def_speed <= 8'd30;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_DEADBAND:  r_deadband  <= pwdata[RSSI_W-1:0];
                REG_ANGLE_MIN: r_angle_min <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_MAX: r_angle_max <= pwdata[ANGLE_W-1:0];
                REG_DIR_NEG:   r_dir_neg   <= pwdata[0];
                REG_DEF_SPEED: r_def_speed <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DEADBAND:  prdata = 32'(r_deadband);
            REG_ANGLE_MIN: prdata = 32'(r_angle_min);
            REG_ANGLE_MAX: prdata = 32'(r_angle_max);
            REG_DIR_NEG:   prdata = 32'(r_dir_neg);
            REG_DEF_SPEED: prdata = 32'(r_def_speed);
            default:       prdata = '0;
        endcase
    end

    // percent numerators and ranges against min/max before this item
    assign l_num   = PCT_W'($signed({1'b0, i_left_rssi}) - $signed({1'b0, r_llow}))
                     * PCT_W'(100);
    assign r_num_w = PCT_W'($signed({1'b0, i_right_rssi}) - $signed({1'b0, r_rlow}))
                     * PCT_W'(100);
    assign l_den   = $signed({1'b0, r_lhigh}) - $signed({1'b0, r_llow});
    assign r_den_w = $signed({1'b0, r_rhigh}) - $signed({1'b0, r_rlow});

    rat_div u_ldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (l_num),
        .i_den   (l_den),
        .o_busy  (ldiv_busy),
        .o_quot  (l_quot)
    );

    rat_div u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (r_num_w),
        .i_den   (r_den_w),
        .o_busy  (rdiv_busy),
        .o_quot  (r_quot)
    );

    // history read at accept, written back in the update cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_hist[r_ptr];
        end
        if (r_state == S_UPD) begin
            r_hist[r_ptr] <= {r_l, r_r};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (accept) begin
                r_rd_vld <= r_hist_vld[r_ptr];
            end
            if (r_state == S_UPD) begin
                r_hist_vld[r_ptr] <= 1'b1;
            end
        end
    end

    assign old_l = r_rd_vld ? r_rd_data[2*RSSI_W-1:RSSI_W] : '0;
    assign old_r = r_rd_vld ? r_rd_data[RSSI_W-1:0] : '0;

    // window averages raised to the channel minimum
    always_comb begin
        avg_l = r_lprod[RECIP_K +: RSSI_W];
        avg_r = r_rprod[RECIP_K +: RSSI_W];
        if (avg_l < r_llow) begin
            avg_l = r_llow;
        end
        if (avg_r < r_rlow) begin
            avg_r = r_rlow;
        end
        diff = (avg_l > avg_r) ? (avg_l - avg_r) : (avg_r - avg_l);
    end

    rat_step_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (diff),
        .o_data (step_q)
    );
    assign step_rd = RSSI_W'(step_q);

    always_comb begin
        if (!r_move) begin
            new_angle = $signed({2'b00, r_pan});
        end else if (r_neg) begin
            new_angle = $signed({2'b00, r_pan}) - $signed(step_rd);
        end else begin
            new_angle = $signed({2'b00, r_pan}) + $signed(step_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_lsum    <= '0;
            r_rsum    <= '0;
            r_llow    <= '0;
            r_lhigh   <= '0;
            r_rlow    <= '0;
            r_rhigh   <= '0;
            r_pan     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (done_go) begin
                r_out_vld <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_lsum <= r_lsum - SUM_W'(old_l) + SUM_W'(r_l);
                    r_rsum <= r_rsum - SUM_W'(old_r) + SUM_W'(r_r);
                    r_ptr  <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
                    // zero means unset
                    if (r_l <= r_llow || r_llow == '0) begin
                        r_llow <= r_l;
                    end
                    if (r_l >= r_lhigh || r_lhigh == '0) begin
                        r_lhigh <= r_l;
                    end
                    if (r_r <= r_rlow || r_rlow == '0) begin
                        r_rlow <= r_r;
                    end
                    if (r_r >= r_rhigh || r_rhigh == '0) begin
                        r_rhigh <= r_r;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_state <= S_ROM;
                end
                S_ROM: begin
                    if (r_cmd) begin
                        r_pan <= clamp_angle($signed({2'b00, r_tgt}), r_angle_min,
                                             r_angle_max);
                    end else begin
                        r_pan <= clamp_angle(new_angle, r_angle_min, r_angle_max);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (done_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_l   <= i_left_rssi;
            r_r   <= i_right_rssi;
            r_tgt <= i_target_angle;
        end
        if (r_state == S_MUL) begin
            r_lprod <= PROD_W'(r_lsum) * PROD_W'(RECIP_M);
            r_rprod <= PROD_W'(r_rsum) * PROD_W'(RECIP_M);
        end
        if (r_state == S_AVG) begin
            r_move <= (diff > r_deadband);
            r_neg  <= (avg_r > avg_l) ^ r_dir_neg;
        end
        if (r_state == S_ROM) begin
            r_speed <= r_cmd ? CAL_SPEED : r_def_speed;
        end
        if (done_go) begin
            r_out_angle <= r_pan;
            r_out_speed <= r_speed;
            r_out_lp    <= l_quot;
            r_out_rp    <= r_quot;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_servo_angle   = r_out_angle;
    assign o_pan_speed     = r_out_speed;
    assign o_left_percent  = r_out_lp;
    assign o_right_percent = r_out_rp;

endmodule
